FILE: rtl/usbep0_pkg.sv
// Shared types, codes and constants for the EP0 standard request engine.
`timescale 1ns / 1ps

package usbep0_pkg;

    localparam int BUFFER_BYTES_DEF = 512;
    localparam int PACKET_BYTES_DEF = 64;

    localparam logic [2:0] CMD_RESET   = 3'd0;
    localparam logic [2:0] CMD_SUSPEND = 3'd1;
    localparam logic [2:0] CMD_RESUME  = 3'd2;
    localparam logic [2:0] CMD_SOF     = 3'd3;
    localparam logic [2:0] CMD_SETUP   = 3'd4;
    localparam logic [2:0] CMD_DONE    = 3'd5;
    localparam logic [2:0] CMD_ERROR   = 3'd6;

    localparam logic [1:0] TYPE_STANDARD = 2'd0;
    localparam logic [1:0] TYPE_CLASS    = 2'd1;
    localparam logic [1:0] TYPE_VENDOR   = 2'd2;

    localparam logic [4:0] RCPT_DEVICE    = 5'd0;
    localparam logic [4:0] RCPT_INTERFACE = 5'd1;
    localparam logic [4:0] RCPT_ENDPOINT  = 5'd2;

    localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
    localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
    localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDRESS       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
    localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

    localparam logic [7:0] DESC_DEVICE    = 8'd1;
    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_STRING    = 8'd3;
    localparam logic [7:0] DESC_QUALIFIER = 8'd6;

    localparam logic [9:0] LEN_DEVICE     = 10'd18;
    localparam logic [9:0] LEN_CFG_HEADER = 10'd9;
    localparam logic [9:0] LEN_LANGUAGE   = 10'd4;
    localparam logic [9:0] LEN_QUALIFIER  = 10'd10;
    localparam logic [9:0] LEN_STATUS     = 10'd2;
    localparam logic [9:0] LEN_BYTE       = 10'd1;

    localparam logic [7:0] CFG_SELF_POWERED      = 8'd0;
    localparam logic [7:0] CFG_VENDOR_ID         = 8'd1;
    localparam logic [7:0] CFG_PRODUCT_ID        = 8'd2;
    localparam logic [7:0] CFG_DEVICE_VERSION    = 8'd3;
    localparam logic [7:0] CFG_MAX_POWER         = 8'd4;
    localparam logic [7:0] CFG_INTERFACE_COUNT   = 8'd5;
    localparam logic [7:0] CFG_CLASS_DESC_LENGTH = 8'd6;

    typedef enum logic [3:0] {
        ACT_NONE       = 4'd0,
        ACT_ACK        = 4'd1,
        ACT_STALL      = 4'd2,
        ACT_SEND       = 4'd3,
        ACT_ROUTE      = 4'd4,
        ACT_REARM      = 4'd5,
        ACT_HALT       = 4'd6,
        ACT_CLEAR_HALT = 4'd7,
        ACT_CONFIG     = 4'd8,
        ACT_DECONFIG   = 4'd9,
        ACT_STRING     = 4'd10
    } action_t;

    typedef enum logic [2:0] {
        SRC_IMM       = 3'd0,
        SRC_DEVICE    = 3'd1,
        SRC_QUALIFIER = 3'd2,
        SRC_LANGUAGE  = 3'd3,
        SRC_CONFIG    = 3'd4
    } src_t;

    typedef enum logic [1:0] {
        DS_DEFAULT    = 2'd0,
        DS_ADDRESSED  = 2'd1,
        DS_CONFIGURED = 2'd2,
        DS_SUSPENDED  = 2'd3
    } dstate_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  endpoint_address;
        logic [15:0] transfer_length;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
        logic        endpoint_halted;
    } evt_t;

    typedef struct packed {
        action_t     action;
        src_t        data_source;
        logic [8:0]  chunk_offset;
        logic [6:0]  chunk_length;
        logic [15:0] immediate_data;
        logic        arm_status_out;
        dstate_t     device_state;
        logic [6:0]  device_address;
        logic [7:0]  target;
    } res_t;

    typedef struct packed {
        logic       self_powered;
        logic [8:0] class_desc_length;
    } cfg_t;

endpackage

FILE: rtl/usbep0_if.sv
// Channel interfaces: bus events in, EP0 results out, configuration writes.
`timescale 1ns / 1ps

interface usbep0_evt_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [7:0]  endpoint_address;
    logic [15:0] transfer_length;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] request_value;
    logic [15:0] request_index;
    logic [15:0] request_length;
    logic        endpoint_halted;

    modport source (output valid, cmd, endpoint_address, transfer_length, request_type,
                    request_code, request_value, request_index, request_length,
                    endpoint_halted, input ready);
    modport sink (input valid, cmd, endpoint_address, transfer_length, request_type,
                  request_code, request_value, request_index, request_length,
                  endpoint_halted, output ready);
endinterface

interface usbep0_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  action;
    logic [2:0]  data_source;
    logic [8:0]  chunk_offset;
    logic [6:0]  chunk_length;
    logic [15:0] immediate_data;
    logic        arm_status_out;
    logic [1:0]  device_state;
    logic [6:0]  device_address;
    logic [7:0]  target;

    modport source (output valid, action, data_source, chunk_offset, chunk_length,
                    immediate_data, arm_status_out, device_state, device_address, target,
                    input ready);
    modport sink (input valid, action, data_source, chunk_offset, chunk_length,
                  immediate_data, arm_status_out, device_state, device_address, target,
                  output ready);
endinterface

interface usbep0_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/usb_ep0_standard_request_engine_unit.sv
// Top level of the EP0 standard request engine: channels, config registers, pipeline.
`timescale 1ns / 1ps

//  channel  dir  transaction
//  evt      in   one bus event (reset, suspend, resume, sof, setup, done, error)
//  res      out  one EP0 result per event
//  cfg      in   one register write (index, data)
//
//  Two register stages: an input register and a result register, one event per cycle while the result is not stalled.
//  An accepted event waits in the input register; its result is registered when the engine steps.
//  A stalled result holds the result register; the input register still takes an event
//  while it is empty, and refills in the cycle the result is taken.
//  Reset clears the device state, address, transmit position and config registers.
//  Config writes are taken in every cycle.

module usb_ep0_standard_request_engine_unit #(
    parameter int BUFFER_BYTES = usbep0_pkg::BUFFER_BYTES_DEF,
    parameter int PACKET_BYTES = usbep0_pkg::PACKET_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    usbep0_evt_if.sink   evt,
    usbep0_res_if.source res,
    usbep0_cfg_if.sink   cfg
);
    import usbep0_pkg::*;

    evt_t evt_reg;
    logic in_vld_reg;
    res_t res_reg;
    res_t res_comb;
    logic out_vld_reg;
    cfg_t cfg_reg;
    evt_t evt_word;
    logic advance;

    assign advance   = in_vld_reg && (!out_vld_reg || res.ready);
    assign evt.ready = !in_vld_reg || advance;
    assign cfg.ready = 1'b1;

    assign evt_word.cmd              = evt.cmd;
    assign evt_word.endpoint_address = evt.endpoint_address;
    assign evt_word.transfer_length  = evt.transfer_length;
    assign evt_word.request_type     = evt.request_type;
    assign evt_word.request_code     = evt.request_code;
    assign evt_word.request_value    = evt.request_value;
    assign evt_word.request_index    = evt.request_index;
    assign evt_word.request_length   = evt.request_length;
    assign evt_word.endpoint_halted  = evt.endpoint_halted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (evt.ready)
                in_vld_reg <= evt.valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (res.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
            evt_reg <= evt_word;
        if (advance)
            res_reg <= res_comb;
    end

    // descriptor identity field writes are accepted but not kept here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index) inside
                CFG_SELF_POWERED:      cfg_reg.self_powered      <= cfg.data[0];
                CFG_CLASS_DESC_LENGTH: cfg_reg.class_desc_length <= cfg.data[8:0];
                CFG_VENDOR_ID, CFG_PRODUCT_ID, CFG_DEVICE_VERSION,
                CFG_MAX_POWER, CFG_INTERFACE_COUNT:
                begin
                    cfg_reg <= cfg_reg;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    usbep0_engine #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .PACKET_BYTES (PACKET_BYTES)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .evt_i (evt_reg),
        .cfg_i (cfg_reg),
        .res_o (res_comb)
    );

    assign res.valid          = out_vld_reg;
    assign res.action         = res_reg.action;
    assign res.data_source    = res_reg.data_source;
    assign res.chunk_offset   = res_reg.chunk_offset;
    assign res.chunk_length   = res_reg.chunk_length;
    assign res.immediate_data = res_reg.immediate_data;
    assign res.arm_status_out = res_reg.arm_status_out;
    assign res.device_state   = res_reg.device_state;
    assign res.device_address = res_reg.device_address;
    assign res.target         = res_reg.target;

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("result lost after engine step");

    a_no_step_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_vld_reg |-> !advance)
        else $error("engine stepped without an event");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !res.ready |=> out_vld_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule

FILE: rtl/usbep0_engine.sv
// Device state, EP0 transmit position and the standard request decode.
`timescale 1ns / 1ps

module usbep0_engine #(
    parameter int BUFFER_BYTES = 512,
    parameter int PACKET_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  usbep0_pkg::evt_t  evt_i,
    input  usbep0_pkg::cfg_t  cfg_i,
    output usbep0_pkg::res_t  res_o
);
    import usbep0_pkg::*;

    localparam int RW = $clog2(BUFFER_BYTES + 1);
    localparam int PW = $clog2(PACKET_BYTES + 1);

    dstate_t       ds_reg, ds_next;
    logic [6:0]    addr_reg, addr_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [RW-1:0] off_reg, off_next;
    src_t          src_reg, src_next;

    logic [1:0]    rq_type;
    logic [4:0]    rq_rcpt;
    logic [7:0]    tgt;
    logic [7:0]    desc_kind;
    logic [7:0]    desc_idx;

    action_t       act;
    logic [7:0]    act_tgt;
    logic          tx_new;
    logic          tx_cont;
    logic [9:0]    len_sel;
    src_t          src_sel;
    logic          imm_bit;

    logic [15:0]   t_min;
    logic [RW-1:0] t_clip;
    logic [RW-1:0] base_rem;
    logic [RW-1:0] base_off;
    logic [PW-1:0] chunk;
    logic [RW-1:0] rem_after;
    logic [RW-1:0] off_after;
    src_t          chunk_src;

    assign rq_type   = evt_i.request_type[6:5];
    assign rq_rcpt   = evt_i.request_type[4:0];
    assign tgt       = evt_i.request_index[7:0];
    assign desc_kind = evt_i.request_value[15:8];
    assign desc_idx  = evt_i.request_value[7:0];

    // length clip to host request and buffer, then one packet's worth
    assign t_min     = ({6'd0, len_sel} < evt_i.request_length) ? {6'd0, len_sel}
                                                                 : evt_i.request_length;
    assign t_clip    = (t_min > 16'(BUFFER_BYTES)) ? RW'(BUFFER_BYTES) : RW'(t_min);
    assign base_rem  = tx_new ? t_clip : rem_reg;
    assign base_off  = tx_new ? '0 : off_reg;
    assign chunk     = (base_rem > RW'(PACKET_BYTES)) ? PW'(PACKET_BYTES) : PW'(base_rem);
    assign rem_after = base_rem - RW'(chunk);
    assign off_after = base_off + RW'(chunk);
    assign chunk_src = tx_new ? src_sel : src_reg;

    always_comb
    begin
        ds_next   = ds_reg;
        addr_next = addr_reg;
        rem_next  = rem_reg;
        off_next  = off_reg;
        src_next  = src_reg;
        act       = ACT_NONE;
        act_tgt   = 8'd0;
        tx_new    = 1'b0;
        tx_cont   = 1'b0;
        len_sel   = 10'd0;
        src_sel   = SRC_IMM;
        imm_bit   = 1'b0;

        unique case (evt_i.cmd)
            CMD_RESET:
            begin
                ds_next   = DS_DEFAULT;
                addr_next = 7'd0;
                rem_next  = '0;
                off_next  = '0;
                src_next  = SRC_IMM;
            end
            CMD_SUSPEND:
            begin
                ds_next = DS_SUSPENDED;
            end
            CMD_SETUP:
            begin
                rem_next = '0;
                off_next = '0;
                src_next = SRC_IMM;
                act      = ACT_STALL;
                if (rq_type == TYPE_STANDARD && rq_rcpt == RCPT_DEVICE)
                begin
                    unique case (evt_i.request_code) inside
                        REQ_GET_STATUS:
                        begin
                            tx_new  = 1'b1;
                            len_sel = LEN_STATUS;
                            imm_bit = cfg_i.self_powered;
                        end
                        REQ_CLEAR_FEATURE, REQ_SET_FEATURE:
                        begin
                            act = ACT_ACK;
                        end
                        REQ_SET_ADDRESS:
                        begin
                            addr_next = evt_i.request_value[6:0];
                            ds_next   = (evt_i.request_value[6:0] != 7'd0) ? DS_ADDRESSED
                                                                           : DS_DEFAULT;
                            act       = ACT_ACK;
                        end
                        REQ_GET_DESCRIPTOR:
                        begin
                            unique case (desc_kind)
                                DESC_DEVICE:
                                begin
                                    tx_new  = 1'b1;
                                    src_sel = SRC_DEVICE;
                                    len_sel = LEN_DEVICE;
                                end
                                DESC_CONFIG:
                                begin
                                    tx_new  = 1'b1;
                                    src_sel = SRC_CONFIG;
                                    len_sel = LEN_CFG_HEADER + {1'b0, cfg_i.class_desc_length};
                                end
                                DESC_STRING:
                                begin
                                    if (desc_idx == 8'd0)
                                    begin
                                        tx_new  = 1'b1;
                                        src_sel = SRC_LANGUAGE;
                                        len_sel = LEN_LANGUAGE;
                                    end
                                    else
                                    begin
                                        act     = ACT_STRING;
                                        act_tgt = desc_idx;
                                    end
                                end
                                DESC_QUALIFIER:
                                begin
                                    tx_new  = 1'b1;
                                    src_sel = SRC_QUALIFIER;
                                    len_sel = LEN_QUALIFIER;
                                end
                                default:
                                begin
                                    act = ACT_STALL;
                                end
                            endcase
                        end
                        REQ_GET_CONFIGURATION:
                        begin
                            tx_new  = 1'b1;
                            len_sel = LEN_BYTE;
                            imm_bit = (ds_reg == DS_CONFIGURED);
                        end
                        REQ_SET_CONFIGURATION:
                        begin
                            if (evt_i.request_value[7:0] == 8'd0)
                            begin
                                ds_next = DS_ADDRESSED;
                                act     = ACT_DECONFIG;
                            end
                            else
                            begin
                                ds_next = DS_CONFIGURED;
                                act     = ACT_CONFIG;
                            end
                        end
                        default:
                        begin
                            act = ACT_STALL;
                        end
                    endcase
                end
                else if (rq_type == TYPE_STANDARD && rq_rcpt == RCPT_INTERFACE)
                begin
                    if (evt_i.request_code == REQ_GET_INTERFACE)
                    begin
                        tx_new  = 1'b1;
                        len_sel = LEN_BYTE;
                    end
                    else if (evt_i.request_code == REQ_SET_INTERFACE)
                    begin
                        act     = ACT_ROUTE;
                        act_tgt = tgt;
                    end
                end
                else if (rq_type == TYPE_STANDARD && rq_rcpt == RCPT_ENDPOINT)
                begin
                    unique case (evt_i.request_code)
                        REQ_GET_STATUS:
                        begin
                            tx_new  = 1'b1;
                            len_sel = LEN_STATUS;
                            imm_bit = evt_i.endpoint_halted;
                        end
                        REQ_CLEAR_FEATURE:
                        begin
                            if (evt_i.request_value == 16'd0)
                            begin
                                act     = ACT_CLEAR_HALT;
                                act_tgt = tgt;
                            end
                        end
                        REQ_SET_FEATURE:
                        begin
                            if (evt_i.request_value == 16'd0)
                            begin
                                act     = ACT_HALT;
                                act_tgt = tgt;
                            end
                        end
                        default:
                        begin
                            act = ACT_STALL;
                        end
                    endcase
                end
                else if ((rq_type == TYPE_CLASS || rq_type == TYPE_VENDOR) &&
                         (rq_rcpt == RCPT_INTERFACE || rq_rcpt == RCPT_ENDPOINT))
                begin
                    act     = ACT_ROUTE;
                    act_tgt = tgt;
                end
            end
            CMD_DONE:
            begin
                if (evt_i.endpoint_address[6:0] != 7'd0)
                begin
                    act     = ACT_ROUTE;
                    act_tgt = evt_i.endpoint_address;
                end
                else if (evt_i.endpoint_address[7])
                begin
                    if (rem_reg != '0)
                        tx_cont = 1'b1;
                    else
                        act = (evt_i.transfer_length == 16'd0) ? ACT_REARM : ACT_NONE;
                end
                else
                begin
                    act = (evt_i.transfer_length == 16'd0) ? ACT_REARM : ACT_ROUTE;
                end
            end
            CMD_ERROR:
            begin
                act     = ACT_ROUTE;
                act_tgt = evt_i.endpoint_address;
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase

        if (tx_new || tx_cont)
        begin
            rem_next = rem_after;
            off_next = off_after;
            src_next = chunk_src;
        end
    end

    always_comb
    begin
        res_o                = '0;
        res_o.action         = act;
        res_o.target         = act_tgt;
        res_o.device_state   = ds_next;
        res_o.device_address = addr_next;
        if (tx_new || tx_cont)
        begin
            res_o.action         = ACT_SEND;
            res_o.target         = 8'd0;
            res_o.data_source    = chunk_src;
            res_o.chunk_offset   = 9'(base_off);
            res_o.chunk_length   = 7'(chunk);
            res_o.immediate_data = {15'd0, imm_bit & tx_new & (chunk_src == SRC_IMM)};
            res_o.arm_status_out = (rem_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ds_reg   <= DS_DEFAULT;
            addr_reg <= 7'd0;
            rem_reg  <= '0;
            off_reg  <= '0;
            src_reg  <= SRC_IMM;
        end
        else if (step)
        begin
            ds_reg   <= ds_next;
            addr_reg <= addr_next;
            rem_reg  <= rem_next;
            off_reg  <= off_next;
            src_reg  <= src_next;
        end
    end

    // position and remainder never add up past the buffer
    a_tx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, rem_reg} + {1'b0, off_reg}) <= (RW + 1)'(BUFFER_BYTES))
        else $error("transmit position beyond buffer");

    a_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
        step && evt_i.cmd == CMD_RESET |=>
        rem_reg == '0 && addr_reg == 7'd0 && ds_reg == DS_DEFAULT)
        else $error("bus reset left state behind");

    a_more_chunks: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_o.action == ACT_SEND && !res_o.arm_status_out |=> rem_reg != '0)
        else $error("chunk not final but nothing left to send");

endmodule

FILE: tb/ep0_request_checker.sv
// Checker for the EP0 request engine: predicts each answer and compares it on the result channel.
`timescale 1ns / 1ps

module ep0_request_checker (
    input  logic  clk,
    input  logic  rst_n,
    usbep0_evt_if evt,
    usbep0_res_if res,
    usbep0_cfg_if cfg,
    output int    errors,
    output int    outstanding
);
    import usbep0_pkg::*;

    localparam logic [9:0] PKT = 10'(PACKET_BYTES_DEF);
    localparam int unsigned BUF = BUFFER_BYTES_DEF;
    localparam int REPORT_LINES = 200;

    dstate_t    dev_state;
    logic [6:0] dev_addr;
    logic [9:0] tx_left;
    logic [9:0] tx_pos;
    src_t       tx_src;
    logic       self_pw;
    logic [8:0] class_len;

    res_t pending_answers[$];

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (errors < REPORT_LINES)
            $display("%0t ep0 mismatch %s: got %0h want %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic res_t plain(action_t act, logic [7:0] tgt);
        res_t r;
        r = '0;
        r.action = act;
        r.target = tgt;
        return r;
    endfunction

    function automatic res_t send_chunk(logic [15:0] imm);
        res_t r;
        logic [9:0] c;
        r = '0;
        c = (tx_left > PKT) ? PKT : tx_left;
        r.action = ACT_SEND;
        r.data_source = tx_src;
        r.chunk_offset = tx_pos[8:0];
        r.chunk_length = c[6:0];
        r.immediate_data = (tx_src == SRC_IMM) ? imm : 16'h0000;
        tx_pos = tx_pos + c;
        tx_left = tx_left - c;
        r.arm_status_out = (tx_left == 10'd0);
        return r;
    endfunction

    function automatic res_t start_transfer(src_t src, int unsigned len, logic [15:0] req,
                                            logic [15:0] imm);
        int unsigned t;
        t = (len < int'(req)) ? len : int'(req);
        if (t > BUF)
            t = BUF;
        tx_src = src;
        tx_pos = '0;
        tx_left = 10'(t);
        return send_chunk(imm);
    endfunction

    function automatic res_t answer_event(evt_t e);
        res_t r;
        logic [1:0] rtype;
        logic [4:0] rcpt;
        logic [7:0] tgt;
        logic [7:0] kind;
        logic [7:0] idx;
        rtype = e.request_type[6:5];
        rcpt = e.request_type[4:0];
        tgt = e.request_index[7:0];
        kind = e.request_value[15:8];
        idx = e.request_value[7:0];
        r = plain(ACT_NONE, 8'h00);
        case (e.cmd)
            CMD_RESET:
            begin
                dev_state = DS_DEFAULT;
                dev_addr = '0;
                tx_left = '0;
                tx_pos = '0;
                tx_src = SRC_IMM;
            end
            CMD_SUSPEND: dev_state = DS_SUSPENDED;
            CMD_SETUP:
            begin
                // a new setup drops any data stage still in flight
                tx_left = '0;
                tx_pos = '0;
                tx_src = SRC_IMM;
                r = plain(ACT_STALL, 8'h00);
                if (rtype == TYPE_STANDARD) begin
                    case (rcpt)
                        RCPT_DEVICE:
                        case (e.request_code)
                            REQ_GET_STATUS:
                                r = start_transfer(SRC_IMM, LEN_STATUS, e.request_length,
                                                   {15'd0, self_pw});
                            REQ_CLEAR_FEATURE, REQ_SET_FEATURE: r = plain(ACT_ACK, 8'h00);
                            REQ_SET_ADDRESS:
                            begin
                                dev_addr = e.request_value[6:0];
                                dev_state = (dev_addr != 7'd0) ? DS_ADDRESSED : DS_DEFAULT;
                                r = plain(ACT_ACK, 8'h00);
                            end
                            REQ_GET_DESCRIPTOR:
                            case (kind)
                                DESC_DEVICE:
                                    r = start_transfer(SRC_DEVICE, LEN_DEVICE, e.request_length,
                                                       16'h0000);
                                DESC_CONFIG:
                                    r = start_transfer(SRC_CONFIG,
                                                       int'(LEN_CFG_HEADER) + int'(class_len),
                                                       e.request_length, 16'h0000);
                                DESC_STRING:
                                    if (idx == 8'h00)
                                        r = start_transfer(SRC_LANGUAGE, LEN_LANGUAGE,
                                                           e.request_length, 16'h0000);
                                    else
                                        r = plain(ACT_STRING, idx);
                                DESC_QUALIFIER:
                                    r = start_transfer(SRC_QUALIFIER, LEN_QUALIFIER,
                                                       e.request_length, 16'h0000);
                                default: ;
                            endcase
                            REQ_GET_CONFIGURATION:
                                r = start_transfer(SRC_IMM, LEN_BYTE, e.request_length,
                                                   {15'd0, dev_state == DS_CONFIGURED});
                            REQ_SET_CONFIGURATION:
                                if (idx == 8'h00) begin
                                    dev_state = DS_ADDRESSED;
                                    r = plain(ACT_DECONFIG, 8'h00);
                                end else begin
                                    dev_state = DS_CONFIGURED;
                                    r = plain(ACT_CONFIG, 8'h00);
                                end
                            default: ;
                        endcase
                        RCPT_INTERFACE:
                            if (e.request_code == REQ_GET_INTERFACE)
                                r = start_transfer(SRC_IMM, LEN_BYTE, e.request_length,
                                                   16'h0000);
                            else if (e.request_code == REQ_SET_INTERFACE)
                                r = plain(ACT_ROUTE, tgt);
                        RCPT_ENDPOINT:
                        case (e.request_code)
                            REQ_GET_STATUS:
                                r = start_transfer(SRC_IMM, LEN_STATUS, e.request_length,
                                                   {15'd0, e.endpoint_halted});
                            REQ_CLEAR_FEATURE:
                                if (e.request_value == 16'h0000)
                                    r = plain(ACT_CLEAR_HALT, tgt);
                            REQ_SET_FEATURE:
                                if (e.request_value == 16'h0000)
                                    r = plain(ACT_HALT, tgt);
                            default: ;
                        endcase
                        default: ;
                    endcase
                end else if ((rtype == TYPE_CLASS || rtype == TYPE_VENDOR) &&
                             (rcpt == RCPT_INTERFACE || rcpt == RCPT_ENDPOINT)) begin
                    r = plain(ACT_ROUTE, tgt);
                end
            end
            CMD_DONE:
                if (e.endpoint_address[6:0] != 7'd0)
                    r = plain(ACT_ROUTE, e.endpoint_address);
                else if (e.endpoint_address[7]) begin
                    if (tx_left != 10'd0)
                        r = send_chunk(16'h0000);
                    else if (e.transfer_length == 16'h0000)
                        r = plain(ACT_REARM, 8'h00);
                end else if (e.transfer_length == 16'h0000)
                    r = plain(ACT_REARM, 8'h00);
                else
                    r = plain(ACT_ROUTE, 8'h00);
            CMD_ERROR: r = plain(ACT_ROUTE, e.endpoint_address);
            default: ;
        endcase
        r.device_state = dev_state;
        r.device_address = dev_addr;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        res_t want;
        evt_t seen;
        if (!rst_n) begin
            dev_state = DS_DEFAULT;
            dev_addr = '0;
            tx_left = '0;
            tx_pos = '0;
            tx_src = SRC_IMM;
            self_pw = 1'b0;
            class_len = '0;
            pending_answers.delete();
            outstanding = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_SELF_POWERED: self_pw = cfg.data[0];
                    CFG_CLASS_DESC_LENGTH: class_len = cfg.data[8:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("unexpected result, action", res.action, 0);
                end else begin
                    want = pending_answers.pop_front();
                    if (res.action !== want.action)
                        report_mismatch("action", res.action, want.action);
                    if (res.data_source !== want.data_source)
                        report_mismatch("data_source", res.data_source, want.data_source);
                    if (res.chunk_offset !== want.chunk_offset)
                        report_mismatch("chunk_offset", res.chunk_offset, want.chunk_offset);
                    if (res.chunk_length !== want.chunk_length)
                        report_mismatch("chunk_length", res.chunk_length, want.chunk_length);
                    if (res.immediate_data !== want.immediate_data)
                        report_mismatch("immediate_data", res.immediate_data,
                                        want.immediate_data);
                    if (res.arm_status_out !== want.arm_status_out)
                        report_mismatch("arm_status_out", res.arm_status_out,
                                        want.arm_status_out);
                    if (res.device_state !== want.device_state)
                        report_mismatch("device_state", res.device_state, want.device_state);
                    if (res.device_address !== want.device_address)
                        report_mismatch("device_address", res.device_address,
                                        want.device_address);
                    if (res.target !== want.target)
                        report_mismatch("target", res.target, want.target);
                end
            end
            if (evt.valid && evt.ready) begin
                seen = {evt.cmd, evt.endpoint_address, evt.transfer_length, evt.request_type,
                        evt.request_code, evt.request_value, evt.request_index,
                        evt.request_length, evt.endpoint_halted};
                pending_answers.push_back(answer_event(seen));
            end
            outstanding = pending_answers.size();
        end
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the EP0 request engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import usbep0_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;

    localparam logic [7:0] RT_DEV_IN    = {1'b1, TYPE_STANDARD, RCPT_DEVICE};
    localparam logic [7:0] RT_DEV_OUT   = {1'b0, TYPE_STANDARD, RCPT_DEVICE};
    localparam logic [7:0] RT_IF_IN     = {1'b1, TYPE_STANDARD, RCPT_INTERFACE};
    localparam logic [7:0] RT_IF_OUT    = {1'b0, TYPE_STANDARD, RCPT_INTERFACE};
    localparam logic [7:0] RT_EP_IN     = {1'b1, TYPE_STANDARD, RCPT_ENDPOINT};
    localparam logic [7:0] RT_EP_OUT    = {1'b0, TYPE_STANDARD, RCPT_ENDPOINT};
    localparam logic [7:0] RT_CLASS_DEV = {1'b1, TYPE_CLASS, RCPT_DEVICE};
    localparam logic [7:0] RT_VEND_EP   = {1'b0, TYPE_VENDOR, RCPT_ENDPOINT};
    localparam logic [7:0] RT_RSVD_TYPE = {1'b1, 2'd3, RCPT_INTERFACE};
    localparam logic [7:0] RT_RSVD_RCPT = {1'b1, TYPE_STANDARD, 5'd3};

    logic clk;
    logic rst_n;
    int   errors;
    int   outstanding;
    int   cycles;
    int   send_idle;
    int   recv_stall;
    int   hold_reqs;
    int   hold_taken;
    int   hold_left;

    usbep0_evt_if evt ();
    usbep0_res_if res ();
    usbep0_cfg_if cfg ();

    usb_ep0_standard_request_engine_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .res   (res),
        .cfg   (cfg)
    );

    ep0_request_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .res         (res),
        .cfg         (cfg),
        .errors      (errors),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            cycles <= 0;
        else
            cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_taken <= 0;
            hold_left <= 0;
            res.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else if (hold_taken != hold_reqs)
        begin
            hold_taken <= hold_taken + 1;
            hold_left <= HOLD_CYCLES;
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic evt_t bus_event(logic [2:0] c, logic [7:0] ep, logic [15:0] tlen);
        evt_t e;
        e.cmd = c;
        e.endpoint_address = ep;
        e.transfer_length = tlen;
        e.request_type = 8'($urandom);
        e.request_code = 8'($urandom);
        e.request_value = 16'($urandom);
        e.request_index = 16'($urandom);
        e.request_length = 16'($urandom);
        e.endpoint_halted = 1'($urandom);
        return e;
    endfunction

    function automatic evt_t setup_event(logic [7:0] rt, logic [7:0] code, logic [15:0] value,
                                         logic [15:0] index, logic [15:0] length, logic halted);
        evt_t e;
        e = bus_event(CMD_SETUP, 8'($urandom), 16'($urandom));
        e.request_type = rt;
        e.request_code = code;
        e.request_value = value;
        e.request_index = index;
        e.request_length = length;
        e.endpoint_halted = halted;
        return e;
    endfunction

    // mostly well-formed setups and EP0 IN completions to walk multi-packet data stages
    function automatic evt_t random_event();
        int unsigned pick;
        logic [1:0]  rtype;
        logic [4:0]  rcpt;
        logic [7:0]  code;
        logic [2:0]  c;
        logic [15:0] value;
        logic [15:0] length;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            rtype = ($urandom_range(9) < 7) ? TYPE_STANDARD : 2'($urandom);
            rcpt = ($urandom_range(9) < 8) ? 5'($urandom_range(2)) : 5'($urandom);
            case ($urandom_range(11))
                0: code = REQ_GET_STATUS;
                1: code = REQ_CLEAR_FEATURE;
                2: code = REQ_SET_FEATURE;
                3: code = REQ_SET_ADDRESS;
                4, 5: code = REQ_GET_DESCRIPTOR;
                6: code = REQ_GET_CONFIGURATION;
                7: code = REQ_SET_CONFIGURATION;
                8: code = REQ_GET_INTERFACE;
                9: code = REQ_SET_INTERFACE;
                10: code = REQ_SET_DESCRIPTOR;
                default: code = 8'($urandom);
            endcase
            value = 16'($urandom);
            if (code == REQ_GET_DESCRIPTOR)
            begin
                case ($urandom_range(4))
                    0: value[15:8] = DESC_DEVICE;
                    1: value[15:8] = DESC_CONFIG;
                    2: value[15:8] = DESC_STRING;
                    3: value[15:8] = DESC_QUALIFIER;
                    default: ;
                endcase
                if ($urandom_range(1) == 0)
                    value[7:0] = 8'h00;
            end
            else if ((code == REQ_CLEAR_FEATURE || code == REQ_SET_FEATURE) &&
                     $urandom_range(3) != 0)
            begin
                value = 16'h0000;
            end
            else if ($urandom_range(3) == 0)
            begin
                value[7:0] = 8'h00;
            end
            case ($urandom_range(7))
                0: length = 16'h0000;
                1: length = 16'($urandom_range(1, 20));
                2: length = 16'($urandom_range(60, 70));
                3: length = 16'($urandom_range(500, 520));
                4: length = 16'hFFFF;
                5: length = 16'($urandom_range(127, 130));
                default: length = 16'($urandom);
            endcase
            return setup_event({1'($urandom), rtype, rcpt}, code, value, 16'($urandom),
                               length, 1'($urandom));
        end
        else if (pick < 75)
        begin
            return bus_event(CMD_DONE, 8'h80,
                             ($urandom_range(2) == 0) ? 16'h0000 : 16'($urandom));
        end
        else if (pick < 83)
        begin
            return bus_event(CMD_DONE, 8'h00,
                             ($urandom_range(1) == 0) ? 16'h0000 : 16'($urandom));
        end
        else if (pick < 90)
        begin
            c = ($urandom_range(1) == 0) ? CMD_DONE : CMD_ERROR;
            return bus_event(c, 8'($urandom), 16'($urandom));
        end
        else
        begin
            case ($urandom_range(3))
                0: c = CMD_RESET;
                1: c = CMD_SUSPEND;
                2: c = CMD_RESUME;
                default: c = CMD_SOF;
            endcase
            return bus_event(c, 8'($urandom), 16'($urandom));
        end
    endfunction

    task automatic offer_event(input evt_t e);
        evt.valid <= 1'b1;
        evt.cmd <= e.cmd;
        evt.endpoint_address <= e.endpoint_address;
        evt.transfer_length <= e.transfer_length;
        evt.request_type <= e.request_type;
        evt.request_code <= e.request_code;
        evt.request_value <= e.request_value;
        evt.request_index <= e.request_index;
        evt.request_length <= e.request_length;
        evt.endpoint_halted <= e.endpoint_halted;
        do @(posedge clk); while (!evt.ready);
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            evt.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
    endtask

    task automatic drain();
        evt.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic set_registers(input logic sp, input logic [15:0] vid, input logic [15:0] pid,
                                 input logic [15:0] ver, input logic [7:0] pwr,
                                 input logic [7:0] ifc, input logic [8:0] cdl);
        write_reg(CFG_SELF_POWERED, {15'd0, sp});
        write_reg(CFG_VENDOR_ID, vid);
        write_reg(CFG_PRODUCT_ID, pid);
        write_reg(CFG_DEVICE_VERSION, ver);
        write_reg(CFG_MAX_POWER, {8'd0, pwr});
        write_reg(CFG_INTERFACE_COUNT, {8'd0, ifc});
        write_reg(CFG_CLASS_DESC_LENGTH, {7'd0, cdl});
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_reqs = 0;
        evt.valid = 1'b0;
        evt.cmd = CMD_SOF;
        evt.endpoint_address = '0;
        evt.transfer_length = '0;
        evt.request_type = '0;
        evt.request_code = '0;
        evt.request_value = '0;
        evt.request_index = '0;
        evt.request_length = '0;
        evt.endpoint_halted = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed transactions, registers at their top values
        set_registers(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 9'd503);
        offer_event(bus_event(CMD_RESET, 8'h00, 16'h0000));
        offer_event(setup_event(RT_DEV_OUT, REQ_SET_ADDRESS, 16'h007F, 16'h0000, 16'h0000, 1'b0));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'h0000,
                                16'hFFFF, 1'b0));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DESC_CONFIG, 8'h00}, 16'h0000,
                                16'hFFFF, 1'b0));
        offer_event(bus_event(CMD_DONE, 8'h80, 16'd64));
        offer_event(bus_event(CMD_DONE, 8'h80, 16'd64));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        offer_event(bus_event(CMD_DONE, 8'h80, 16'h0000));
        offer_event(bus_event(CMD_DONE, 8'h80, 16'hFFFF));
        offer_event(setup_event(RT_DEV_OUT, REQ_SET_CONFIGURATION, 16'h0001, 16'h0000,
                                16'h0000, 1'b0));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_CONFIGURATION, 16'h0000, 16'h0000,
                                16'h0001, 1'b0));
        offer_event(setup_event(RT_DEV_OUT, REQ_SET_CONFIGURATION, 16'hFF00, 16'h0000,
                                16'h0000, 1'b0));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'h00}, 16'h0409,
                                16'h0003, 1'b0));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DESC_STRING, 8'hFF}, 16'h0409,
                                16'h00FF, 1'b0));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_DESCRIPTOR, {DESC_QUALIFIER, 8'h00},
                                16'h0000, 16'hFFFF, 1'b0));
        offer_event(setup_event(RT_DEV_IN, REQ_GET_DESCRIPTOR, 16'hFFFF, 16'h0000, 16'h0040,
                                1'b0));
        offer_event(setup_event(RT_DEV_OUT, REQ_SET_DESCRIPTOR, {DESC_DEVICE, 8'h00}, 16'h0000,
                                16'h0012, 1'b0));
        offer_event(setup_event(RT_IF_IN, REQ_GET_INTERFACE, 16'h0000, 16'h0000, 16'h0001,
                                1'b0));
        offer_event(setup_event(RT_IF_OUT, REQ_SET_INTERFACE, 16'h0001, 16'hFFFF, 16'h0000,
                                1'b0));
        offer_event(setup_event(RT_EP_IN, REQ_GET_STATUS, 16'h0000, 16'h0081, 16'h0002, 1'b1));
        offer_event(setup_event(RT_EP_OUT, REQ_CLEAR_FEATURE, 16'h0000, 16'h0081, 16'h0000,
                                1'b1));
        offer_event(setup_event(RT_EP_OUT, REQ_SET_FEATURE, 16'h0001, 16'h0002, 16'h0000,
                                1'b0));
        offer_event(setup_event(RT_CLASS_DEV, 8'h01, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        offer_event(setup_event(RT_VEND_EP, 8'hFF, 16'hFFFF, 16'h00FF, 16'hFFFF, 1'b1));
        offer_event(setup_event(RT_RSVD_TYPE, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002,
                                1'b0));
        offer_event(setup_event(RT_RSVD_RCPT, REQ_GET_STATUS, 16'h0000, 16'h0000, 16'h0002,
                                1'b0));
        offer_event(bus_event(CMD_DONE, 8'h00, 16'h0000));
        offer_event(bus_event(CMD_DONE, 8'h00, 16'h0005));
        offer_event(bus_event(CMD_DONE, 8'hFF, 16'hFFFF));
        offer_event(bus_event(CMD_ERROR, 8'h00, 16'h0000));
        offer_event(bus_event(CMD_SUSPEND, 8'h00, 16'h0000));
        offer_event(bus_event(CMD_RESUME, 8'h00, 16'h0000));
        offer_event(bus_event(CMD_SOF, 8'h00, 16'h0000));
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                    set_registers(1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 9'd0);
                end
                1:
                begin
                    send_idle = 85;
                    recv_stall = 0;
                    set_registers(1'b1, 16'($urandom), 16'($urandom), 16'($urandom),
                                  8'($urandom), 8'($urandom), 9'd55);
                end
                2:
                begin
                    send_idle = 0;
                    recv_stall = 85;
                    set_registers(1'b0, 16'($urandom), 16'($urandom), 16'($urandom),
                                  8'($urandom), 8'($urandom), 9'd119);
                end
                3:
                begin
                    send_idle = 38;
                    recv_stall = 38;
                    set_registers(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                  8'($urandom), 8'($urandom), 9'($urandom_range(503)));
                end
                default:
                begin
                    send_idle = 0;
                    recv_stall = 0;
                    set_registers(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF, 8'h00, 9'd503);
                end
            endcase
            repeat (200) offer_event(random_event());
            drain();
        end

        // long hold-off on the result side while events keep coming
        send_idle = 0;
        recv_stall = 0;
        hold_reqs = hold_reqs + 1;
        repeat (40) offer_event(random_event());
        drain();
        repeat (40) offer_event(random_event());
        drain();

        repeat (10) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
